[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ECI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ECI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/eci_pkg.sv]
// Shared types, constants and fixed-point helpers of the easing curve interpolator.
// No dependencies; imported by every module of the block.
package eci_pkg;

  // Field and bus widths
  localparam int unsigned KIND_W       = 4;
  localparam int unsigned TIME_W       = 13;
  localparam int unsigned EASED_W      = 14;
  localparam int unsigned PORT_VALUE_W = 32;
  localparam int unsigned S_TDATA_W    = 80;
  localparam int unsigned M_TDATA_W    = 48;

  // Defaults and sizing
  localparam int unsigned VALUE_BITS_DEF   = 32;
  localparam int unsigned ECI_FIFO_DEPTH   = 4;
  localparam int unsigned ECI_BACK_STAGES  = 6;
  // front register + queue + back pipeline
  localparam int unsigned ECI_MAX_INFLIGHT = 1 + ECI_FIFO_DEPTH + ECI_BACK_STAGES;

  // Q12 constants
  localparam logic [TIME_W-1:0]         Q_ONE_U  = 13'd4096;
  localparam logic [TIME_W-1:0]         Q_HALF_U = 13'd2048;
  localparam logic signed [EASED_W-1:0] Q_ONE_S  = 14'sd4096;

  // Back-out coefficients
  localparam logic signed [15:0] BACK_C3 = 16'sd11065;
  localparam logic signed [15:0] BACK_C2 = 16'sd6969;

  // Bounce-out arcs
  localparam logic signed [15:0]        BNC_K   = 16'sd30976;
  localparam logic [TIME_W-1:0]         BNC_T1  = 13'd1489;
  localparam logic [TIME_W-1:0]         BNC_T2  = 13'd2979;
  localparam logic [TIME_W-1:0]         BNC_T3  = 13'd3724;
  localparam logic signed [EASED_W-1:0] BNC_C1  = 14'sd2234;
  localparam logic signed [EASED_W-1:0] BNC_C2  = 14'sd3351;
  localparam logic signed [EASED_W-1:0] BNC_C3  = 14'sd3910;
  localparam logic signed [EASED_W-1:0] BNC_O1  = 14'sd3072;
  localparam logic signed [EASED_W-1:0] BNC_O2  = 14'sd3840;
  localparam logic signed [EASED_W-1:0] BNC_O3  = 14'sd4032;

  // Curve kinds on the input side
  typedef enum logic [KIND_W-1:0] {
    KIND_LINEAR    = 4'd0,
    KIND_QUAD_IN   = 4'd1,
    KIND_QUAD_OUT  = 4'd2,
    KIND_QUAD_IO   = 4'd3,
    KIND_CUBIC_IN  = 4'd4,
    KIND_CUBIC_OUT = 4'd5,
    KIND_CUBIC_IO  = 4'd6,
    KIND_BACK_OUT  = 4'd7,
    KIND_BOUNCE    = 4'd8,
    KIND_STEP      = 4'd9,
    KIND_SHAKE     = 4'd10
  } kind_e;

  // Operation classes seen by the back end
  typedef enum logic [2:0] {
    OP_CONST  = 3'd0,  // eased = base
    OP_SQ     = 3'd1,  // square of m, scaled and mirrored
    OP_CUBE   = 3'd2,  // cube of m, scaled and mirrored
    OP_BACK   = 3'd3,  // back-out polynomial in m
    OP_BOUNCE = 3'd4,  // K * m^2 + base
    OP_SHAKE  = 3'd5   // base + sdiff * frac
  } op_e;

  // Classified curve work handed from front to back
  typedef struct packed {
    op_e                        op;
    logic                       inv;    // result is 1.0 - x
    logic [1:0]                 shl;    // x scaled by 2^shl
    logic signed [EASED_W-1:0]  m;      // operand to square or cube
    logic signed [EASED_W-1:0]  base;   // constant part
    logic signed [EASED_W-1:0]  sdiff;  // shake segment slope
    logic [11:0]                frac;   // shake position in segment
  } crv_t;

  // Shake breakpoints, Q12
  function automatic logic signed [EASED_W-1:0] shake_pt(input logic [2:0] idx);
    logic signed [EASED_W-1:0] pt;
    unique case (idx)
      3'd0:    pt = 14'sd0;
      3'd1:    pt = 14'sd4096;
      3'd2:    pt = -14'sd3072;
      3'd3:    pt = 14'sd2304;
      3'd4:    pt = -14'sd1536;
      3'd5:    pt = 14'sd768;
      3'd6:    pt = -14'sd256;
      default: pt = 14'sd0;
    endcase
    return pt;
  endfunction

  // Q12 product rounding, half away from zero
  function automatic logic signed [27:0] rnd_q12(input logic signed [39:0] p);
    logic signed [39:0] s;
    s = p + (p[39] ? 40'sd2047 : 40'sd2048);
    return s[39:12];
  endfunction

  // Q12 scaling, truncating toward zero
  function automatic logic signed [27:0] trunc_q12(input logic signed [39:0] p);
    logic signed [39:0] s;
    s = p + (p[39] ? 40'sd4095 : 40'sd0);
    return s[39:12];
  endfunction

endpackage

[hw/rtl/easing_curve_interpolator.sv]
// Easing curve interpolator: Q12 eased fraction and interpolated value per item.
// Top level; depends on eci_pkg, eci_front, eci_fifo and eci_back.
//
// Usage:
//   Slave stream carries one request per word: tuser holds the curve kind,
//   tdata holds time, start value and target value. The master stream returns
//   one word per request, in order: eased fraction and interpolated value.
//   From accept to the result on m_axis an item passes through one front
//   register, the queue and six back stages. Throughput is one item per clock
//   while m_axis_tready stays high, set by the back pipeline, which issues one
//   multiply stage after another and takes a new item every such cycle.
//   When the receiver holds tready low the back pipeline freezes with its
//   result on the output register; the front keeps taking items until the
//   four-entry queue and the front register are full, then s_axis_tready drops.
//   Reset clears all valid flags and queue pointers; nothing else is held,
//   no item carries state over to the next one.
module easing_curve_interpolator import eci_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // time_frac[12:0], start_value[44:13], target_value[76:45], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // kind[3:0]
  input  logic [KIND_W-1:0]    s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // eased_frac[13:0], result_value[45:14], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned QW = VALUE_BITS - 11;
  localparam int unsigned QUEUE_W = $bits(crv_t) + VALUE_BITS + QW + 13;

  logic                         fr_valid, fr_ready;
  crv_t                         fr_crv, bk_crv;
  logic signed [VALUE_BITS-1:0] fr_from, bk_from, bk_value;
  logic signed [QW-1:0]         fr_q, bk_q;
  logic signed [12:0]           fr_r, bk_r;
  logic                         bk_valid, bk_ready;
  logic [QUEUE_W-1:0]           qu_in, qu_out;
  logic signed [EASED_W-1:0]    bk_eased;
  logic signed [PORT_VALUE_W-1:0] value_ext;

  // Front: classify and split the difference
  eci_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .time_i      (s_axis_tdata_i[12:0]),
    .start_i     (s_axis_tdata_i[44:13]),
    .target_i    (s_axis_tdata_i[76:45]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .crv_o       (fr_crv),
    .from_o      (fr_from),
    .q_o         (fr_q),
    .r_o         (fr_r)
  );

  // Queue between the two halves
  assign qu_in = {fr_crv, fr_from, fr_q, fr_r};

  eci_fifo #(
    .WIDTH (QUEUE_W),
    .DEPTH (ECI_FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (qu_in),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (qu_out)
  );

  assign {bk_crv, bk_from, bk_q, bk_r} = qu_out;

  // Back: curve evaluation and interpolation
  eci_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .crv_i       (bk_crv),
    .from_i      (bk_from),
    .q_i         (bk_q),
    .r_i         (bk_r),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .eased_o     (bk_eased),
    .value_o     (bk_value)
  );

  assign value_ext      = 32'(bk_value);
  assign m_axis_tdata_o = {2'b00, value_ext, bk_eased};

endmodule

[hw/rtl/eci_front.sv]
// Front end: accepts an item, classifies the curve and splits the endpoint difference.
// Depends on eci_pkg.
module eci_front import eci_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [KIND_W-1:0]              kind_i,
  input  logic [TIME_W-1:0]              time_i,
  input  logic [PORT_VALUE_W-1:0]        start_i,
  input  logic [PORT_VALUE_W-1:0]        target_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output crv_t                           crv_o,
  output logic signed [VALUE_BITS-1:0]   from_o,
  output logic signed [VALUE_BITS-12:0]  q_o,
  output logic signed [12:0]             r_o
);

  localparam int unsigned DW = VALUE_BITS + 1;
  localparam int unsigned QW = VALUE_BITS - 11;

  logic                     valid_q, valid_d;
  crv_t                     crv_q, crv_d;
  logic signed [VALUE_BITS-1:0] from_q, from_d, to_v;
  logic signed [QW-1:0]     q_q, q_d;
  logic signed [12:0]       r_q, r_d;
  logic signed [DW-1:0]     diff, diff_adj, rem_full;
  logic [TIME_W-1:0]        t, u;
  logic                     lower;
  logic [14:0]              t7;
  logic [2:0]               seg;
  logic signed [EASED_W-1:0] t_s, u_s, pa, pb;
  logic                     load;

  // Endpoint difference split into coarse quotient and remainder
  always_comb begin
    from_d   = $signed(start_i[VALUE_BITS-1:0]);
    to_v     = $signed(target_i[VALUE_BITS-1:0]);
    diff     = DW'(to_v) - DW'(from_d);
    diff_adj = diff + (diff[DW-1] ? DW'(4095) : DW'(0));
    q_d      = diff_adj[DW-1:12];
    rem_full = diff - $signed({q_d, 12'b0});
    r_d      = rem_full[12:0];
  end

  // Curve classification
  always_comb begin
    t     = time_i;
    u     = Q_ONE_U - t;
    lower = (t < Q_HALF_U);
    t_s   = $signed({1'b0, t});
    u_s   = $signed({1'b0, u});
    t7    = {t[11:0], 3'b000} - {3'b000, t[11:0]};
    seg   = t7[14:12];
    pa    = shake_pt(seg);
    pb    = shake_pt(seg + 3'd1);

    crv_d       = '0;
    crv_d.op    = OP_CONST;
    crv_d.base  = t_s;
    unique case (kind_i)
      KIND_QUAD_IN: begin
        crv_d.op = OP_SQ;
        crv_d.m  = t_s;
      end
      KIND_QUAD_OUT: begin
        crv_d.op  = OP_SQ;
        crv_d.m   = u_s;
        crv_d.inv = 1'b1;
      end
      KIND_QUAD_IO: begin
        crv_d.op  = OP_SQ;
        crv_d.m   = lower ? t_s : u_s;
        crv_d.inv = !lower;
        crv_d.shl = 2'd1;
      end
      KIND_CUBIC_IN: begin
        crv_d.op = OP_CUBE;
        crv_d.m  = t_s;
      end
      KIND_CUBIC_OUT: begin
        crv_d.op  = OP_CUBE;
        crv_d.m   = u_s;
        crv_d.inv = 1'b1;
      end
      KIND_CUBIC_IO: begin
        crv_d.op  = OP_CUBE;
        crv_d.m   = lower ? t_s : u_s;
        crv_d.inv = !lower;
        crv_d.shl = 2'd2;
      end
      KIND_BACK_OUT: begin
        crv_d.op = OP_BACK;
        crv_d.m  = t_s - Q_ONE_S;
      end
      KIND_BOUNCE: begin
        crv_d.op = OP_BOUNCE;
        if (t < BNC_T1) begin
          crv_d.m    = t_s;
          crv_d.base = '0;
        end else if (t < BNC_T2) begin
          crv_d.m    = t_s - BNC_C1;
          crv_d.base = BNC_O1;
        end else if (t < BNC_T3) begin
          crv_d.m    = t_s - BNC_C2;
          crv_d.base = BNC_O2;
        end else begin
          crv_d.m    = t_s - BNC_C3;
          crv_d.base = BNC_O3;
        end
      end
      KIND_STEP: begin
        crv_d.base = '0;
      end
      KIND_SHAKE: begin
        crv_d.op    = OP_SHAKE;
        crv_d.base  = pa;
        crv_d.sdiff = pb - pa;
        crv_d.frac  = t7[11:0];
      end
      default: begin
        // linear and unknown kinds: eased = time
        crv_d.op   = OP_CONST;
        crv_d.base = t_s;
      end
    endcase

    // pinned ends
    if (t == '0) begin
      crv_d      = '0;
      crv_d.op   = OP_CONST;
    end else if (t[TIME_W-1]) begin
      crv_d      = '0;
      crv_d.op   = OP_CONST;
      crv_d.base = (kind_i == KIND_SHAKE) ? '0 : Q_ONE_S;
    end
  end

  // Output register
  assign load       = in_valid_i && in_ready_o;
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      crv_q  <= crv_d;
      from_q <= from_d;
      q_q    <= q_d;
      r_q    <= r_d;
    end
  end

  assign out_valid_o = valid_q;
  assign crv_o       = crv_q;
  assign from_o      = from_q;
  assign q_o         = q_q;
  assign r_o         = r_q;

endmodule

[hw/rtl/eci_fifo.sv]
// Short queue between front and back ends, flip-flop storage, first-word fall-through.
// Depends on eci_pkg.
module eci_fifo import eci_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ECI_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/eci_back.sv]
// Back end: six-stage pipeline that evaluates the curve and interpolates the value.
// Depends on eci_pkg.
module eci_back import eci_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  crv_t                           crv_i,
  input  logic signed [VALUE_BITS-1:0]   from_i,
  input  logic signed [VALUE_BITS-12:0]  q_i,
  input  logic signed [12:0]             r_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [EASED_W-1:0]      eased_o,
  output logic signed [VALUE_BITS-1:0]   value_o
);

  localparam int unsigned QW = VALUE_BITS - 11;
  localparam int unsigned PW = QW + EASED_W;
  localparam int unsigned VW = VALUE_BITS + 4;
  localparam logic signed [VW-1:0] VMAX = $signed({{5{1'b0}}, {(VALUE_BITS-1){1'b1}}});
  localparam logic signed [VW-1:0] VMIN = $signed({{5{1'b1}}, {(VALUE_BITS-1){1'b0}}});

  logic adv;
  logic [ECI_BACK_STAGES-1:0] vld_q, vld_d;

  // stage 1
  crv_t                         s1_crv;
  logic signed [EASED_W-1:0]    s1_m2, s1_sh, m2_d, sh_d;
  logic signed [VALUE_BITS-1:0] s1_from;
  logic signed [QW-1:0]         s1_q;
  logic signed [12:0]           s1_r;
  logic signed [27:0]           p_mm;
  logic signed [26:0]           p_sh;
  // stage 2
  crv_t                         s2_crv;
  logic signed [EASED_W-1:0]    s2_m2, s2_m3, s2_sh, m3_d;
  logic signed [15:0]           s2_k2, s2_bq, k2_d, bq_d;
  logic signed [VALUE_BITS-1:0] s2_from;
  logic signed [QW-1:0]         s2_q;
  logic signed [12:0]           s2_r;
  logic signed [27:0]           p_m3;
  logic signed [29:0]           p_k2, p_bq;
  // stage 3
  logic                         s3_back;
  logic signed [EASED_W-1:0]    s3_pre, pre_d, pw;
  logic signed [15:0]           s3_k3, s3_k2, k3_d, bq_sum;
  logic signed [VALUE_BITS-1:0] s3_from;
  logic signed [QW-1:0]         s3_q;
  logic signed [12:0]           s3_r;
  logic signed [29:0]           p_k3;
  // stage 4
  logic signed [EASED_W-1:0]    s4_e, e_d;
  logic signed [15:0]           back_sum;
  logic signed [VALUE_BITS-1:0] s4_from;
  logic signed [QW-1:0]         s4_q;
  logic signed [12:0]           s4_r;
  // stage 5
  logic signed [EASED_W-1:0]    s5_e;
  logic signed [PW-1:0]         s5_qe, qe_d;
  logic signed [14:0]           s5_rr, rr_d;
  logic signed [26:0]           p_re;
  logic signed [VALUE_BITS-1:0] s5_from;
  // stage 6
  logic signed [EASED_W-1:0]    s6_e;
  logic signed [VALUE_BITS-1:0] s6_v, v_d;
  logic signed [VW-1:0]         v_sum;

  // Whole pipeline moves together; the last stage is the output register
  assign adv        = !vld_q[ECI_BACK_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[ECI_BACK_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: square of the operand, shake slope term
  always_comb begin
    p_mm = $signed(crv_i.m) * $signed(crv_i.m);
    m2_d = 14'(rnd_q12(40'(p_mm)));
    p_sh = $signed(crv_i.sdiff) * $signed({1'b0, crv_i.frac});
    sh_d = 14'(trunc_q12(40'(p_sh)));
  end

  // Stage 2: cube and the constant products of the square
  always_comb begin
    p_m3 = s1_m2 * $signed(s1_crv.m);
    m3_d = 14'(rnd_q12(40'(p_m3)));
    p_k2 = BACK_C2 * s1_m2;
    k2_d = 16'(rnd_q12(40'(p_k2)));
    p_bq = BNC_K * s1_m2;
    bq_d = 16'(rnd_q12(40'(p_bq)));
  end

  // Stage 3: back-out cubic term, eased value of the other curves
  always_comb begin
    p_k3   = BACK_C3 * s2_m3;
    k3_d   = 16'(rnd_q12(40'(p_k3)));
    bq_sum = s2_bq + 16'(s2_crv.base);
    pw     = '0;
    pre_d  = '0;
    unique case (s2_crv.op)
      OP_CONST: pre_d = s2_crv.base;
      OP_SQ: begin
        pw    = s2_m2 <<< s2_crv.shl;
        pre_d = s2_crv.inv ? Q_ONE_S - pw : pw;
      end
      OP_CUBE: begin
        pw    = s2_m3 <<< s2_crv.shl;
        pre_d = s2_crv.inv ? Q_ONE_S - pw : pw;
      end
      OP_BOUNCE: pre_d = bq_sum[EASED_W-1:0];
      OP_SHAKE:  pre_d = s2_crv.base + s2_sh;
      OP_BACK:   pre_d = '0;
      default:   pre_d = '0;
    endcase
  end

  // Stage 4: final eased fraction
  always_comb begin
    back_sum = 16'(Q_ONE_S) + s3_k3 + s3_k2;
    e_d      = s3_back ? back_sum[EASED_W-1:0] : s3_pre;
  end

  // Stage 5: coarse and rounded fine products of the difference
  always_comb begin
    qe_d = s4_q * s4_e;
    p_re = s4_r * s4_e;
    rr_d = 15'(rnd_q12(40'(p_re)));
  end

  // Stage 6: sum and saturate
  always_comb begin
    v_sum = VW'(s5_from) + VW'(s5_qe) + VW'(s5_rr);
    if (v_sum > VMAX) begin
      v_d = VMAX[VALUE_BITS-1:0];
    end else if (v_sum < VMIN) begin
      v_d = VMIN[VALUE_BITS-1:0];
    end else begin
      v_d = v_sum[VALUE_BITS-1:0];
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_crv  <= crv_i;
      s1_m2   <= m2_d;
      s1_sh   <= sh_d;
      s1_from <= from_i;
      s1_q    <= q_i;
      s1_r    <= r_i;

      s2_crv  <= s1_crv;
      s2_m2   <= s1_m2;
      s2_m3   <= m3_d;
      s2_sh   <= s1_sh;
      s2_k2   <= k2_d;
      s2_bq   <= bq_d;
      s2_from <= s1_from;
      s2_q    <= s1_q;
      s2_r    <= s1_r;

      s3_back <= (s2_crv.op == OP_BACK);
      s3_pre  <= pre_d;
      s3_k3   <= k3_d;
      s3_k2   <= s2_k2;
      s3_from <= s2_from;
      s3_q    <= s2_q;
      s3_r    <= s2_r;

      s4_e    <= e_d;
      s4_from <= s3_from;
      s4_q    <= s3_q;
      s4_r    <= s3_r;

      s5_e    <= s4_e;
      s5_qe   <= qe_d;
      s5_rr   <= rr_d;
      s5_from <= s4_from;

      s6_e    <= s5_e;
      s6_v    <= v_d;
    end
  end

  assign out_valid_o = vld_q[ECI_BACK_STAGES-1];
  assign eased_o     = s6_e;
  assign value_o     = s6_v;

endmodule

[hw/rtl/eci_checker.sv]
// Port-level checker for the easing curve interpolator, bound to the top level.
// Depends on eci_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eci_checker import eci_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_tvalid_i,
  input logic                 in_tready_i,
  input logic                 out_tvalid_i,
  input logic                 out_tready_i,
  input logic [M_TDATA_W-1:0] out_tdata_i
);

  localparam int unsigned OW = $clog2(ECI_MAX_INFLIGHT + 2);

  logic [OW-1:0] outstanding_q, outstanding_d;
  logic          in_acc, out_acc;

  // Items taken in but not yet delivered
  assign in_acc  = in_tvalid_i && in_tready_i;
  assign out_acc = out_tvalid_i && out_tready_i;

  always_comb begin
    outstanding_d = outstanding_q + OW'(in_acc) - OW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  `ECI_ASSERT(a_out_hold, clk_i, rst_ni, out_tvalid_i && !out_tready_i |=> out_tvalid_i && $stable(out_tdata_i), "result changed while stalled")

  `ECI_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_tvalid_i, "result valid during reset")

  `ECI_ASSERT(a_no_invented, clk_i, rst_ni, out_tvalid_i |-> outstanding_q != '0, "result without a pending request")

  `ECI_ASSERT(a_inflight_bound, clk_i, rst_ni, outstanding_q <= OW'(ECI_MAX_INFLIGHT), "more items in flight than storage")

endmodule

bind easing_curve_interpolator eci_checker u_eci_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_tvalid_i  (s_axis_tvalid_i),
  .in_tready_i  (s_axis_tready_o),
  .out_tvalid_i (m_axis_tvalid_o),
  .out_tready_i (m_axis_tready_i),
  .out_tdata_i  (m_axis_tdata_o)
);

[tb/tb.sv]
// Self-checking testbench for easing_curve_interpolator: Q12 easing curves and value blend.
// Depends on eci_pkg and the easing_curve_interpolator RTL; streams random and corner words
// through both stream ports with random idle bursts and checks every result in order.
`timescale 1ns / 100ps

module tb;
  import eci_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_WORDS = 1030;
  localparam int unsigned QUIET_WORDS  = 200;  // tail of the run without idling
  localparam int unsigned DRAIN_CYCLES = 32;

  // Q12 and curve constants
  localparam longint Q1        = 4096;
  localparam longint QH        = 2048;
  localparam longint BACK_CUBE = 11065;
  localparam longint BACK_SQR  = 6969;
  localparam longint BNC_GAIN  = 30976;
  localparam longint BNC_EDGE1 = 1489;
  localparam longint BNC_EDGE2 = 2979;
  localparam longint BNC_EDGE3 = 3724;
  localparam longint BNC_MID1  = 2234;
  localparam longint BNC_MID2  = 3351;
  localparam longint BNC_MID3  = 3910;
  localparam longint BNC_LIFT1 = 3072;
  localparam longint BNC_LIFT2 = 3840;
  localparam longint BNC_LIFT3 = 4032;
  localparam int     SHAKE_PTS [8] = '{0, 16, -12, 9, -6, 3, -1, 0};  // units of 256

  localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 4'd11;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 4'd15;
  localparam logic [TIME_W-1:0] TIME_MAX        = 13'd8191;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [EASED_W-1:0] frac;
    logic signed [31:0]        value;
  } blend_t;

  // Scoreboard: predicts eased fraction and blended value, checks results in order
  class curve_scoreboard;
    blend_t      expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Q12 product, rounded half away from zero
    function longint qprod(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return (p + QH) / Q1;
      return -((-p + QH) / Q1);
    endfunction

    function longint bounce_arc(longint x, longint lift);
      return qprod(BNC_GAIN, qprod(x, x)) + lift;
    endfunction

    function longint eased_curve(logic [KIND_W-1:0] kind, longint t);
      longint u, u2, u3, seg, pos, a, b;
      if (t <= 0) return 0;
      if (t >= Q1) return (kind == KIND_SHAKE) ? 0 : Q1;
      case (kind)
        KIND_QUAD_IN: return qprod(t, t);
        KIND_QUAD_OUT: begin
          u = Q1 - t;
          return Q1 - qprod(u, u);
        end
        KIND_QUAD_IO: begin
          if (t < QH) return 2 * qprod(t, t);
          u = Q1 - t;
          return Q1 - 2 * qprod(u, u);
        end
        KIND_CUBIC_IN: return qprod(qprod(t, t), t);
        KIND_CUBIC_OUT: begin
          u = Q1 - t;
          return Q1 - qprod(qprod(u, u), u);
        end
        KIND_CUBIC_IO: begin
          if (t < QH) return 4 * qprod(qprod(t, t), t);
          u = Q1 - t;
          return Q1 - 4 * qprod(qprod(u, u), u);
        end
        KIND_BACK_OUT: begin
          u  = t - Q1;
          u2 = qprod(u, u);
          u3 = qprod(u2, u);
          return Q1 + qprod(BACK_CUBE, u3) + qprod(BACK_SQR, u2);
        end
        KIND_BOUNCE: begin
          if (t < BNC_EDGE1) return qprod(BNC_GAIN, qprod(t, t));
          if (t < BNC_EDGE2) return bounce_arc(t - BNC_MID1, BNC_LIFT1);
          if (t < BNC_EDGE3) return bounce_arc(t - BNC_MID2, BNC_LIFT2);
          return bounce_arc(t - BNC_MID3, BNC_LIFT3);
        end
        KIND_STEP: return 0;
        KIND_SHAKE: begin
          // seven even segments between the breakpoints; slope division truncates
          seg = (t * 7) / Q1;
          if (seg > 6) seg = 6;
          pos = t * 7 - seg * Q1;
          a   = longint'(SHAKE_PTS[seg]) * 256;
          b   = longint'(SHAKE_PTS[seg + 1]) * 256;
          return a + ((b - a) * pos) / Q1;
        end
        default: return t;
      endcase
    endfunction

    // Note one accepted request and queue its expected word
    function void note_request(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t,
                               logic signed [31:0] from_v, logic signed [31:0] to_v);
      longint e, d, q, r, v;
      blend_t exp_w;
      e = eased_curve(kind, longint'(t));
      d = longint'(to_v) - longint'(from_v);
      q = d / Q1;
      r = d - q * Q1;
      v = longint'(from_v) + q * e + qprod(r, e);
      if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
      if (v < longint'(VAL_MIN)) v = longint'(VAL_MIN);
      exp_w.frac  = e[EASED_W-1:0];
      exp_w.value = v[31:0];
      expected_q.push_back(exp_w);
    endfunction

    // Compare one accepted result word against the oldest expectation
    function void check_result(logic [M_TDATA_W-1:0] word);
      blend_t exp_w;
      logic signed [EASED_W-1:0] got_frac;
      logic signed [31:0]        got_value;
      got_frac  = word[EASED_W-1:0];
      got_value = word[EASED_W+31:EASED_W];
      if (expected_q.size() == 0) begin
        $error("result word with no request pending: eased_frac %0d result_value %0d",
               got_frac, got_value);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got_frac !== exp_w.frac) begin
        $error("eased_frac: expected %0d, got %0d", exp_w.frac, got_frac);
        errors++;
      end
      if (got_value !== exp_w.value) begin
        $error("result_value: expected %0d, got %0d", exp_w.value, got_value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b1;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [KIND_W-1:0]    s_kind = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;

  bit              quiet = 1'b0;  // no idling on either side
  int unsigned     cycles = 0;
  curve_scoreboard sb = new();

  easing_curve_interpolator u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Handshake monitor on both streams
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready === 1'b1) begin
      sb.note_request(s_kind, s_data[TIME_W-1:0], s_data[TIME_W+31:TIME_W],
                      s_data[TIME_W+63:TIME_W+32]);
    end
    if (rst_n && m_ready && m_valid === 1'b1) begin
      sb.check_result(m_data);
    end
  end

  // Receiver: random stall bursts until the quiet tail
  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Drive one request word and hold it until accepted
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] t,
                              input logic [31:0] from_v, input logic [31:0] to_v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_kind  <= kind;
    s_data  <= {3'b000, to_v, from_v, t};
    do @(posedge clk); while (s_ready !== 1'b1);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return VAL_MAX - $urandom_range(0, 3);
      1:       return VAL_MIN + $urandom_range(0, 3);
      2:       return 32'($urandom_range(0, 20000)) - 32'd10000;
      3:       return 32'($urandom_range(0, 8191));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_ONE_U;
      2:       return 13'($urandom_range(4097, 8191));
      3:       return 13'($urandom_range(0, 16));
      4:       return 13'($urandom_range(4080, 4095));
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
    return 4'($urandom_range(KIND_LINEAR, KIND_SHAKE));
  endfunction

  initial begin
    // falling edge at time zero so the asynchronous reset takes effect at once
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every kind at an interior time
    for (int k = KIND_LINEAR; k <= KIND_SHAKE; k++) begin
      send_request(4'(k), 13'($urandom_range(1, 4095)), pick_value(), pick_value());
    end
    // Pinned ends, time past the end, full-scale endpoints
    send_request(KIND_BACK_OUT, '0, VAL_MIN, VAL_MAX);
    send_request(KIND_SHAKE, Q_ONE_U, 32'd12345, VAL_MAX);
    send_request(KIND_QUAD_IO, TIME_MAX, VAL_MAX, VAL_MIN);
    send_request(KIND_CUBIC_IN, Q_ONE_U, VAL_MIN, VAL_MAX);
    // Unknown kind acts as linear; step just before the end
    send_request(KIND_UNKNOWN_HI, 13'd4095, VAL_MIN, VAL_MAX);
    send_request(KIND_STEP, 13'd4095, 32'd100, 32'd200);
    // Bounce arc boundaries and in-out midpoints
    send_request(KIND_BOUNCE, 13'd1489, 32'd0, 32'd409600);
    send_request(KIND_BOUNCE, 13'd2979, 32'd0, 32'd409600);
    send_request(KIND_BOUNCE, 13'd3724, 32'd0, 32'd409600);
    send_request(KIND_QUAD_IO, Q_HALF_U, 32'd7, -32'd7);
    send_request(KIND_CUBIC_IO, 13'd2047, -32'd5000, 32'd5000);
    // Full-scale span: back-out overshooting into saturation, shake at the end of its first segment
    send_request(KIND_BACK_OUT, 13'd2900, VAL_MIN, VAL_MAX);
    send_request(KIND_SHAKE, 13'd585, VAL_MAX, VAL_MIN);

    // Random part; the tail runs without idling
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      send_request(pick_kind(), pick_time(), pick_value(), pick_value());
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
